/* hdl/assert_macros.svh */
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PCC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also evaluated during reset.
`define PCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/pcc_pkg.sv */
// Types and constants of the power and clock controller register block.
package pcc_pkg;

	localparam int unsigned ADDR_W = 7;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned FREQ_W = 26;
	localparam int unsigned PLL_DIV_W = 8;
	localparam int unsigned PLL_MUL_W = 11;
	localparam int unsigned IN_TDATA_W = 40;
	localparam int unsigned OUT_TDATA_W = 72;

	// Register offsets.
	localparam logic [ADDR_W-1:0] ADDR_SCER = 7'h00;
	localparam logic [ADDR_W-1:0] ADDR_SCDR = 7'h04;
	localparam logic [ADDR_W-1:0] ADDR_SCSR = 7'h08;
	localparam logic [ADDR_W-1:0] ADDR_PCER = 7'h10;
	localparam logic [ADDR_W-1:0] ADDR_PCDR = 7'h14;
	localparam logic [ADDR_W-1:0] ADDR_PCSR = 7'h18;
	localparam logic [ADDR_W-1:0] ADDR_MOR  = 7'h20;
	localparam logic [ADDR_W-1:0] ADDR_MCFR = 7'h24;
	localparam logic [ADDR_W-1:0] ADDR_PLLA = 7'h28;
	localparam logic [ADDR_W-1:0] ADDR_PLLB = 7'h2c;
	localparam logic [ADDR_W-1:0] ADDR_MCKR = 7'h30;
	localparam logic [ADDR_W-1:0] ADDR_IER  = 7'h60;
	localparam logic [ADDR_W-1:0] ADDR_IDR  = 7'h64;
	localparam logic [ADDR_W-1:0] ADDR_SR   = 7'h68;
	localparam logic [ADDR_W-1:0] ADDR_IMR  = 7'h6c;
	localparam logic [2:0] PROG_PAGE = 3'b100;

	localparam logic OP_READ = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Master clock source select codes.
	localparam logic [1:0] CSS_SLOW = 2'd0;
	localparam logic [1:0] CSS_MAIN = 2'd1;

	localparam logic [DATA_W-1:0] SLOW_FREQ = 32'd32768;
	localparam logic [DATA_W-1:0] PLL_VALID_MASK = 32'h0003_ff80;
	localparam logic [DATA_W-1:0] SYS_CLK_MASK = 32'h0000_0f80;
	localparam logic [DATA_W-1:0] PERIPH_CLK_MASK = 32'hffff_fffc;
	localparam logic [DATA_W-1:0] PLL_RESET = 32'h0000_3f00;
	localparam logic [DATA_W-1:0] MCFR_VALID = 32'h0001_0000;
	localparam int unsigned MCFR_SHIFT = 19;

	// Status register bits.
	localparam int unsigned ST_MOSCS = 0;
	localparam int unsigned ST_LOCKA = 1;
	localparam int unsigned ST_LOCKB = 2;
	localparam int unsigned ST_MCKRDY = 3;
	localparam logic [DATA_W-1:0] STATUS_RESET = 32'h0000_0008;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SRC,
		ST_DIV,
		ST_MUL,
		ST_FIN,
		ST_DONE
	} pcc_state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic div_start;
		logic f_from_src;
		logic f_from_prod;
		logic apply;
		logic out_load;
	} pcc_cmd_t;

	typedef struct packed {
		logic recompute;
		logic pll_go;
		logic div_done;
		logic out_free;
	} pcc_sts_t;

endpackage

/* hdl/power_clock_controller_regs_core.sv */
// Power and clock controller register block: top level.
//
// One bus transaction arrives on the s_axis channel: tuser is the access kind
// (read or write), tdata carries the byte offset and the write data. Each
// transaction yields exactly one result on the m_axis channel with the read
// data, the interrupt line and the current master clock frequency.
// The main oscillator frequency is written on the cfg channel, which is
// always ready; write it only while no transaction is in flight.
// A read, or a write that does not decode, passes through the execute and done
// states and then puts its result into the output register.
// A decoded write recomputes the master clock: with a slow or main source it
// passes through the source, finish and done states; with a PLL source it
// starts the serial divider, which produces one of 26 quotient bits per cycle,
// and waits for it before the multiply, finish and done states.
// One transaction is in flight at a time; the next one is accepted in the
// cycle after its result enters the output register.
// A stalled receiver holds the result in the output register and the block
// waits with its next result until that one is taken.
// Reset restores every register of the register file to its documented reset value and empties
// the output register; no clearing pass is needed.
module power_clock_controller_regs_core
	import pcc_pkg::*;
#(
	parameter int unsigned NUM_PROG_CLOCKS = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [FREQ_W-1:0]      cfg_data,      // main_osc_freq
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // address[6:0], write_data[38:7]
	input  logic                   s_axis_tuser,  // op
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // read_data[31:0], irq[32], master_clock_hz[64:33]
);

	pcc_cmd_t cmd;
	pcc_sts_t sts;

	assign cfg_ready = 1'b1;

	pcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tvalid (s_axis_tvalid),
		.in_tready (s_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pcc_dp #(
		.NUM_PROG_CLOCKS (NUM_PROG_CLOCKS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.in_tdata   (s_axis_tdata),
		.in_tuser   (s_axis_tuser),
		.out_tvalid (m_axis_tvalid),
		.out_tready (m_axis_tready),
		.out_tdata  (m_axis_tdata)
	);

endmodule

/* hdl/pcc_div.sv */
// Restoring serial divider for the PLL input divide, one quotient bit per cycle.
module pcc_div
	import pcc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [FREQ_W-1:0]    dividend,
	input  logic [PLL_DIV_W-1:0] divisor,
	output logic                 done,
	output logic [FREQ_W-1:0]    quotient
);

	localparam int unsigned CNT_W = $clog2(FREQ_W);

	logic                 busy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [PLL_DIV_W-1:0] rem_q;
	logic [FREQ_W-1:0]    quo_q;
	logic [PLL_DIV_W:0]   trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[FREQ_W-1]};
	assign fits = trial >= {1'b0, divisor};
	assign done = busy_q && (cnt_q == '0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(FREQ_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			// The remainder stays below the divisor, so it fits in the divisor width.
			rem_q <= fits ? PLL_DIV_W'(trial - {1'b0, divisor}) : trial[PLL_DIV_W-1:0];
			quo_q <= {quo_q[FREQ_W-2:0], fits};
		end
	end

endmodule

/* hdl/pcc_dp.sv */
// Datapath: register file, address decode, clock computation and result register.
module pcc_dp
	import pcc_pkg::*;
#(
	parameter int unsigned NUM_PROG_CLOCKS = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pcc_cmd_t               cmd,
	output pcc_sts_t               sts,
	input  logic                   cfg_valid,
	input  logic [FREQ_W-1:0]      cfg_data,
	input  logic [IN_TDATA_W-1:0]  in_tdata,
	input  logic                   in_tuser,
	output logic                   out_tvalid,
	input  logic                   out_tready,
	output logic [OUT_TDATA_W-1:0] out_tdata
);

	localparam int unsigned IDX_W = (NUM_PROG_CLOCKS > 1) ? $clog2(NUM_PROG_CLOCKS) : 1;

	logic [FREQ_W-1:0] main_freq_q;
	logic              op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [DATA_W-1:0] wdata_q;

	logic [DATA_W-1:0] sys_clk_q;
	logic [DATA_W-1:0] periph_clk_q;
	logic [DATA_W-1:0] mor_q;
	logic [DATA_W-1:0] plla_q;
	logic [DATA_W-1:0] pllb_q;
	logic [DATA_W-1:0] mckr_q;
	logic [DATA_W-1:0] prog_q [NUM_PROG_CLOCKS];
	logic [DATA_W-1:0] status_q;
	logic [DATA_W-1:0] imr_q;
	logic [DATA_W-1:0] mclk_q;

	logic [DATA_W-1:0] rdata_q;
	logic [DATA_W-1:0] f_q;
	logic              out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic              prog_hit;
	logic [IDX_W-1:0]  prog_idx;
	logic              wr_hit;
	logic [DATA_W-1:0] rd_mux;
	logic [DATA_W-1:0] pll_sel;
	logic              pll_ok;
	logic [DATA_W-1:0] src_freq;
	logic [DATA_W-1:0] scaled;
	logic              div_done;
	logic [FREQ_W-1:0] quotient;
	logic [PLL_MUL_W:0] mul_plus1;
	logic [FREQ_W+PLL_MUL_W:0] product;
	logic              irq;

	// Any byte offset within the programmable clock page picks the word by bits 3:2.
	assign prog_hit = (addr_q[ADDR_W-1:4] == PROG_PAGE) &&
		(32'(addr_q[3:2]) < NUM_PROG_CLOCKS);
	assign prog_idx = IDX_W'(addr_q[3:2]);

	always_comb begin
		wr_hit = prog_hit;
		if (!prog_hit) begin
			unique case (addr_q)
				ADDR_SCER, ADDR_SCDR, ADDR_PCER, ADDR_PCDR, ADDR_MOR,
				ADDR_PLLA, ADDR_PLLB, ADDR_MCKR, ADDR_IER, ADDR_IDR: wr_hit = 1'b1;
				default: wr_hit = 1'b0;
			endcase
		end
	end

	always_comb begin
		rd_mux = '0;
		if (prog_hit) begin
			rd_mux = prog_q[prog_idx];
		end else begin
			unique case (addr_q)
				ADDR_SCSR: rd_mux = sys_clk_q;
				ADDR_PCSR: rd_mux = periph_clk_q;
				ADDR_MOR:  rd_mux = mor_q;
				ADDR_MCFR: rd_mux = mor_q[0] ?
					(MCFR_VALID | DATA_W'(main_freq_q >> MCFR_SHIFT)) : '0;
				ADDR_PLLA: rd_mux = plla_q;
				ADDR_PLLB: rd_mux = pllb_q;
				ADDR_MCKR: rd_mux = mckr_q;
				ADDR_SR:   rd_mux = status_q;
				ADDR_IMR:  rd_mux = imr_q;
				default:   rd_mux = '0;
			endcase
		end
	end

	assign pll_sel = mckr_q[0] ? pllb_q : plla_q;
	assign pll_ok = (pll_sel[PLL_DIV_W-1:0] != '0) && ((pll_sel & PLL_VALID_MASK) != '0);
	assign mul_plus1 = {1'b0, pll_sel[16 +: PLL_MUL_W]} + 1'b1;
	// The full product is kept; the clock value wraps at the data width.
	assign product = quotient * mul_plus1;

	always_comb begin
		unique case (mckr_q[1:0])
			CSS_SLOW: src_freq = SLOW_FREQ;
			CSS_MAIN: src_freq = status_q[ST_MOSCS] ? DATA_W'(main_freq_q) : '0;
			default:  src_freq = '0;
		endcase
	end

	assign scaled = (f_q >> mckr_q[4:2]) >> mckr_q[9:8];
	assign irq = |(status_q & imr_q);

	pcc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (main_freq_q),
		.divisor  (pll_sel[PLL_DIV_W-1:0]),
		.done     (div_done),
		.quotient (quotient)
	);

	assign sts.recompute = (op_q == OP_WRITE) && wr_hit;
	assign sts.pll_go = mckr_q[1] && pll_ok;
	assign sts.div_done = div_done;
	assign sts.out_free = !out_valid_q || out_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_freq_q <= '0;
		end else if (cfg_valid) begin
			main_freq_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= in_tuser;
			addr_q <= in_tdata[ADDR_W-1:0];
			wdata_q <= in_tdata[ADDR_W +: DATA_W];
		end
		if (cmd.exec) begin
			rdata_q <= (op_q == OP_WRITE) ? '0 : rd_mux;
		end
		if (cmd.f_from_src) begin
			f_q <= src_freq;
		end else if (cmd.f_from_prod) begin
			f_q <= product[DATA_W-1:0];
		end
		if (cmd.out_load) begin
			out_data_q <= {7'd0, mclk_q, irq, rdata_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sys_clk_q <= 32'd1;
			periph_clk_q <= '0;
			mor_q <= '0;
			plla_q <= PLL_RESET;
			pllb_q <= PLL_RESET;
			mckr_q <= '0;
			for (int i = 0; i < NUM_PROG_CLOCKS; i++) begin
				prog_q[i] <= '0;
			end
			status_q <= STATUS_RESET;
			imr_q <= '0;
			mclk_q <= SLOW_FREQ;
		end else begin
			if (cmd.exec && (op_q == OP_WRITE)) begin
				if (prog_hit) begin
					prog_q[prog_idx] <= wdata_q;
				end else begin
					unique case (addr_q)
						ADDR_SCER: sys_clk_q <= sys_clk_q | (wdata_q & SYS_CLK_MASK);
						ADDR_SCDR: sys_clk_q <= sys_clk_q & ~(wdata_q & SYS_CLK_MASK);
						ADDR_PCER: periph_clk_q <= periph_clk_q | (wdata_q & PERIPH_CLK_MASK);
						ADDR_PCDR: periph_clk_q <= periph_clk_q & ~(wdata_q & PERIPH_CLK_MASK);
						ADDR_MOR: begin
							mor_q <= wdata_q;
							status_q[ST_MOSCS] <= 1'b1;
						end
						ADDR_PLLA: begin
							plla_q <= wdata_q;
							status_q[ST_LOCKA] <= 1'b1;
						end
						ADDR_PLLB: begin
							pllb_q <= wdata_q;
							status_q[ST_LOCKB] <= 1'b1;
						end
						ADDR_MCKR: mckr_q <= wdata_q;
						ADDR_IER:  imr_q <= imr_q | wdata_q;
						ADDR_IDR:  imr_q <= imr_q & ~wdata_q;
						default: ;
					endcase
				end
			end
			// A zero source frequency only drops the ready flag and keeps the old value.
			if (cmd.apply) begin
				if (f_q != '0) begin
					mclk_q <= scaled;
					status_q[ST_MCKRDY] <= 1'b1;
				end else begin
					status_q[ST_MCKRDY] <= 1'b0;
				end
			end
		end
	end

	assign out_tvalid = out_valid_q;
	assign out_tdata = out_data_q;

endmodule

/* hdl/pcc_ctrl.sv */
// Controller state machine that sequences one bus transaction through the datapath.
module pcc_ctrl
	import pcc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_tvalid,
	output logic     in_tready,
	input  pcc_sts_t sts,
	output pcc_cmd_t cmd
);

	pcc_state_t state_q;
	pcc_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_tready = 1'b1;
				if (in_tvalid) begin
					cmd.capture = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d = sts.recompute ? ST_SRC : ST_DONE;
			end
			ST_SRC: begin
				if (sts.pll_go) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV;
				end else begin
					cmd.f_from_src = 1'b1;
					state_d = ST_FIN;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.f_from_prod = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.apply = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

/* hdl/pcc_checker.sv */
// Port-level checker for the power and clock controller block and its bind.
`include "assert_macros.svh"

module pcc_checker
	import pcc_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// A stalled result must hold its contents.
	`PCC_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
	// Only one transaction is in flight, so acceptance closes the input side.
	`PCC_ASSERT(a_one_in_flight, clk, arst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input accepted while busy")
	// A new result appears exactly when the block returns to idle.
	`PCC_ASSERT(a_result_then_idle, clk, arst_n, $rose(m_axis_tvalid) |-> s_axis_tready, "result without return to idle")
	// No result can be produced in the cycle right after acceptance.
	`PCC_ASSERT(a_min_latency, clk, arst_n, s_axis_tvalid && s_axis_tready |-> ##1 !$rose(m_axis_tvalid), "result too early")
	// Reset empties the output register by the following edge at the latest.
	`PCC_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |=> !m_axis_tvalid, "output valid during reset")

endmodule

bind power_clock_controller_regs_core pcc_checker u_pcc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
